// ----- src/byte_ring_buffer_core_macros.svh -----
// Assertion macros shared by the byte ring buffer RTL.
`ifndef BYTE_RING_BUFFER_CORE_MACROS_SVH
`define BYTE_RING_BUFFER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BRB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define BRB_ASSERT(label, clk, rst_n, prop, msg)
`define BRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/brb_pkg.sv -----
// Shared types, constants and helpers of the byte ring buffer.
`timescale 1ns / 1ps
package brb_pkg;

	localparam int BRB_CAPACITY = 255;
	localparam int WRITE_BYTES  = 8;
	localparam int READ_MAX     = 64;
	localparam int DATA_LANES   = 8;
	localparam int LANE_W       = 3;
	localparam int WCNT_W       = 4;
	localparam int RCNT_W       = 7;
	localparam int CMDQ_DEPTH   = 2;
	localparam int CMDQ_AW      = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int IN_TDATA_W   = 80;
	localparam int OUT_TDATA_W  = 32;

	localparam int WCNT_LSB = 0;
	localparam int RCNT_LSB = WCNT_LSB + WCNT_W;
	localparam int DATA_LSB = RCNT_LSB + RCNT_W;

	typedef logic [1:0] op_t;
	localparam op_t OP_WRITE  = 2'd0;
	localparam op_t OP_READ   = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;
	localparam op_t OP_STATUS = 2'd3;

	typedef struct packed {
		op_t                         op;
		logic [WCNT_W-1:0]           wr_cnt;
		logic [RCNT_W-1:0]           rd_cnt;
		logic [DATA_LANES-1:0][7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic              has_byte;
		logic [7:0]        read_byte;
		logic              last;
		logic [RCNT_W-1:0] moved;
		logic [7:0]        used_space;
		logic [7:0]        free_space;
	} res_t;

	// Pointer width for a store of capacity plus one slots.
	function automatic int brb_ptr_width(input int cap);
		return $clog2(cap + 1);
	endfunction

endpackage

// ----- src/brb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/brb_front.sv -----
// Request decoder and short command queue in front of the buffer engine.
`timescale 1ns / 1ps
`include "byte_ring_buffer_core_macros.svh"
module brb_front
	import brb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic [1:0]            s_tuser,
	output logic                  q_valid,
	input  logic                  q_pop,
	output cmd_t                  q_cmd
);

	cmd_t               dec_cmd;
	cmd_t               ent_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   cnt_q;
	logic               push;
	logic               pop;
	logic [WCNT_W-1:0]  wr_raw;
	logic [RCNT_W-1:0]  rd_raw;

	// Counts beyond what one request may carry are clamped here, so the
	// engine only ever sees legal lengths.
	always_comb begin
		wr_raw = s_tdata[WCNT_LSB +: WCNT_W];
		rd_raw = s_tdata[RCNT_LSB +: RCNT_W];
		dec_cmd.op = s_tuser;
		dec_cmd.wr_cnt = (wr_raw > WCNT_W'(WRITE_BYTES)) ? WCNT_W'(WRITE_BYTES) : wr_raw;
		dec_cmd.rd_cnt = (rd_raw > RCNT_W'(READ_MAX)) ? RCNT_W'(READ_MAX) : rd_raw;
		for (int i = 0; i < DATA_LANES; i++) begin
			dec_cmd.data[i] = s_tdata[DATA_LSB + 8 * i +: 8];
		end
	end

	assign s_tready = (cnt_q != (CMDQ_AW + 1)'(CMDQ_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = ent_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec_cmd;
		end
	end

	`BRB_ASSERT(a_cmdq_bound, clk, arst_n, cnt_q <= (CMDQ_AW + 1)'(CMDQ_DEPTH), "command queue overfilled")

endmodule

// ----- src/brb_back.sv -----
// Buffer engine: executes queued commands against the byte store.
`timescale 1ns / 1ps
`include "byte_ring_buffer_core_macros.svh"
module brb_back
	import brb_pkg::*;
#(
	parameter int CAPACITY = BRB_CAPACITY,
	localparam int PW = brb_ptr_width(CAPACITY)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  cmd_t          q_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output res_t          out_res,
	output logic          ram_we,
	output logic [PW-1:0] ram_waddr,
	output logic [7:0]    ram_wdata,
	output logic          ram_re,
	output logic [PW-1:0] ram_raddr,
	input  logic [7:0]    ram_rdata
);

	localparam int CW = (PW > 8) ? PW : 8;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_WRITE    = 3'd1;
	localparam logic [2:0] ST_RD_ISSUE = 3'd2;
	localparam logic [2:0] ST_RD_DATA  = 3'd3;
	localparam logic [2:0] ST_RESULT   = 3'd4;

	logic [2:0]        state_q;
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [PW-1:0]     used_q;
	logic [LANE_W-1:0] lane_q;
	logic [RCNT_W-1:0] left_q;
	logic [RCNT_W-1:0] moved_q;
	logic              status_q;
	logic              out_valid_q;
	cmd_t              cur_q;
	res_t              out_q;

	logic [CW-1:0] used_w;
	logic [CW-1:0] free_w;
	logic [CW-1:0] wr_n_w;
	logic [CW-1:0] rd_req_w;
	logic [CW-1:0] rd_n_w;
	logic [PW-1:0] head_nxt;
	logic [PW-1:0] tail_nxt;
	logic          out_free;
	logic          res_load;
	res_t          res_nxt;

	always_comb begin
		used_w   = CW'(used_q);
		free_w   = CW'(CAPACITY) - used_w;
		wr_n_w   = CW'(q_cmd.wr_cnt);
		rd_req_w = CW'(q_cmd.rd_cnt);
		rd_n_w   = (rd_req_w < used_w) ? rd_req_w : used_w;
		head_nxt = (head_q == PW'(CAPACITY)) ? '0 : head_q + 1'b1;
		tail_nxt = (tail_q == PW'(CAPACITY)) ? '0 : tail_q + 1'b1;
	end

	assign out_free  = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign ram_we    = (state_q == ST_WRITE);
	assign ram_waddr = tail_q;
	assign ram_wdata = cur_q.data[lane_q];
	assign ram_re    = (state_q == ST_RD_ISSUE);
	assign ram_raddr = head_q;
	assign res_load  = out_free && ((state_q == ST_RESULT) || (state_q == ST_RD_DATA));

	// The used count already holds its value after the whole command when a
	// result is formed, so every result of a read reports the same spaces.
	always_comb begin
		res_nxt.status     = (state_q == ST_RESULT) ? status_q : 1'b0;
		res_nxt.has_byte   = (state_q == ST_RD_DATA);
		res_nxt.read_byte  = (state_q == ST_RD_DATA) ? ram_rdata : 8'd0;
		res_nxt.last       = (state_q == ST_RD_DATA) ? (left_q == '0) : 1'b1;
		res_nxt.moved      = moved_q;
		res_nxt.used_space = (used_w > CW'(255)) ? 8'hFF : used_w[7:0];
		res_nxt.free_space = (free_w > CW'(255)) ? 8'hFF : free_w[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			used_q      <= '0;
			lane_q      <= '0;
			left_q      <= '0;
			moved_q     <= '0;
			status_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						lane_q   <= '0;
						status_q <= 1'b0;
						moved_q  <= '0;
						state_q  <= ST_RESULT;
						unique case (q_cmd.op)
							OP_WRITE: begin
								if (wr_n_w > free_w) begin
									status_q <= 1'b1;
								end else begin
									moved_q <= RCNT_W'(q_cmd.wr_cnt);
									if (q_cmd.wr_cnt != '0) begin
										state_q <= ST_WRITE;
									end
								end
							end
							OP_READ: begin
								moved_q <= RCNT_W'(rd_n_w);
								left_q  <= RCNT_W'(rd_n_w);
								used_q  <= used_q - PW'(rd_n_w);
								if (rd_n_w != '0) begin
									state_q <= ST_RD_ISSUE;
								end
							end
							OP_CLEAR: begin
								head_q <= '0;
								tail_q <= '0;
								used_q <= '0;
							end
							OP_STATUS: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_WRITE: begin
					tail_q <= tail_nxt;
					used_q <= used_q + 1'b1;
					lane_q <= lane_q + 1'b1;
					if (WCNT_W'(lane_q) + WCNT_W'(1) == cur_q.wr_cnt) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RD_ISSUE: begin
					left_q <= left_q - 1'b1;
					// Taking the last byte out rewinds both pointers to slot zero.
					if (used_q == '0 && left_q == RCNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= head_nxt;
					end
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					if (out_free) begin
						state_q <= (left_q == '0) ? ST_IDLE : ST_RD_ISSUE;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
		if (res_load) begin
			out_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`BRB_ASSERT(a_used_bound, clk, arst_n, used_q <= PW'(CAPACITY), "used count above capacity")
	`BRB_ASSERT_IMPL(a_empty_ptrs, clk, arst_n, state_q == ST_IDLE && used_q == '0, head_q == tail_q, "empty buffer with pointers apart")
	`BRB_ASSERT_IMPL(a_rd_order, clk, arst_n, state_q == ST_RD_DATA, $past(state_q) == ST_RD_ISSUE || $past(state_q) == ST_RD_DATA, "read data step without a read issue")

endmodule

// ----- src/byte_ring_buffer_core.sv -----
// Top level of the byte ring buffer: request decoder, command queue, engine and store.
`timescale 1ns / 1ps
// The block is a byte FIFO kept in a circular store of CAPACITY+1 one-byte
// slots, one of which always stays empty so that equal pointers mean empty.
// Each request on the slave stream is a write (up to eight bytes, taken whole
// or refused whole with status 1 when free space is short), a read (up to 64
// bytes, one response per byte with tlast on the final one, or a single empty
// response when nothing can be moved), a clear, or a status query. Every
// response reports the used and free space after the whole request, each
// saturated at 255. Requests pass a two-entry command queue, so the slave side
// keeps accepting while the queue has room, as the engine works or the master side
// stalls. The byte store has a single write and a single read port, one byte
// per cycle. A write is a decode step, a store write per byte and a result
// step; a read a decode step, then an address and a registered data step per
// byte; clear, status, refused writes and empty reads a decode and a result
// step. Result and data steps wait while tready is low. There is no clearing
// pass after reset; the store holds nothing meaningful until written.
module byte_ring_buffer_core
	import brb_pkg::*;
#(
	parameter int CAPACITY = BRB_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// write_count[3:0], read_count[10:4], data0[18:11] ... data7[74:67], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status[0], read_byte[8:1], moved_count[15:9], used_space[23:16], free_space[31:24]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// has_byte[0]
	output logic                   m_tuser,
	output logic                   m_tlast
);

	localparam int PW = brb_ptr_width(CAPACITY);

	logic          q_valid;
	logic          q_pop;
	cmd_t          q_cmd;
	res_t          res;
	logic          ram_we;
	logic [PW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [PW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// The front decodes and clamps requests and queues them.
	brb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd)
	);

	// The engine owns the pointers and the response register.
	brb_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Byte store of CAPACITY+1 slots.
	brb_ram #(
		.WIDTH (8),
		.DEPTH (CAPACITY + 1)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Response packing; the fields fill the data word exactly.
	assign m_tdata = {res.free_space, res.used_space, res.moved, res.read_byte, res.status};
	assign m_tuser = res.has_byte;
	assign m_tlast = res.last;

endmodule
